[rtl/core/kup_pkg.sv]
package kup_pkg;

	localparam int DW = 32;
	localparam int FB = 16;

	// Divider: one quotient bit per step, DIV_STEPS steps per pipeline stage.
	// DW + FB must be a multiple of DIV_STEPS.
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = (DW + FB) / DIV_STEPS;

	localparam int IDX_W = 4;

	typedef logic signed [DW-1:0] q_t;

	localparam q_t QMAX = {1'b0, {(DW-1){1'b1}}};
	localparam q_t QMIN = {1'b1, {(DW-1){1'b0}}};
	localparam q_t ZERO = '0;
	localparam q_t ONE  = q_t'(1) << FB;

	localparam logic [2*DW-1:0] LIM_POS = {{(DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [2*DW-1:0] LIM_NEG = {{DW{1'b0}}, 1'b1, {(DW-1){1'b0}}};

	localparam logic [IDX_W-1:0] REG_MEAS_MAP_00 = 4'd0;
	localparam logic [IDX_W-1:0] REG_MEAS_MAP_01 = 4'd1;
	localparam logic [IDX_W-1:0] REG_MEAS_MAP_10 = 4'd2;
	localparam logic [IDX_W-1:0] REG_MEAS_MAP_11 = 4'd3;
	localparam logic [IDX_W-1:0] REG_NOISE_COV_00 = 4'd4;
	localparam logic [IDX_W-1:0] REG_NOISE_COV_01 = 4'd5;
	localparam logic [IDX_W-1:0] REG_NOISE_COV_10 = 4'd6;
	localparam logic [IDX_W-1:0] REG_NOISE_COV_11 = 4'd7;

	typedef struct packed {
		q_t m00;
		q_t m01;
		q_t m10;
		q_t m11;
	} mat_t;

	typedef struct packed {
		mat_t h;
		mat_t r;
	} cfg_t;

	typedef struct packed {
		q_t x0;
		q_t x1;
		mat_t p;
		q_t z0;
		q_t z1;
	} in_t;

	// Per-item data that rides alongside the gain computation
	typedef struct packed {
		q_t x0;
		q_t x1;
		mat_t p;
		q_t y0;
		q_t y1;
		logic sing;
	} side_t;

	typedef struct packed {
		q_t x0;
		q_t x1;
		mat_t p;
		logic sing;
	} res_t;

	function automatic q_t sat_w(logic signed [DW:0] v);
		if (v[DW] != v[DW-1]) begin
			return v[DW] ? QMIN : QMAX;
		end
		return v[DW-1:0];
	endfunction

	function automatic q_t sadd(q_t a, q_t b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		return sat_w(s);
	endfunction

	function automatic q_t ssub(q_t a, q_t b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} - {b[DW-1], b};
		return sat_w(s);
	endfunction

	function automatic logic [DW-1:0] qmag(q_t a);
		logic [DW-1:0] m;
		m = a[DW-1] ? (~a + 1'b1) : a;
		return m;
	endfunction

	// Product truncated toward zero by FB, then saturated
	function automatic q_t mulq(q_t a, q_t b);
		logic [DW-1:0]   ma;
		logic [DW-1:0]   mb;
		logic [2*DW-1:0] pr;
		logic [2*DW-1:0] sh;
		logic [2*DW-1:0] lim;
		logic            neg;
		ma  = qmag(a);
		mb  = qmag(b);
		pr  = ma * mb;
		sh  = pr >> FB;
		neg = a[DW-1] ^ b[DW-1];
		lim = neg ? LIM_NEG : LIM_POS;
		if (sh > lim) begin
			sh = lim;
		end
		return neg ? q_t'(~sh[DW-1:0] + 1'b1) : q_t'(sh[DW-1:0]);
	endfunction

endpackage

[rtl/core/kup_front.sv]
module kup_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  kup_pkg::in_t   item,
	input  kup_pkg::cfg_t  cfg,
	output logic           out_vld,
	output kup_pkg::mat_t  num,
	output kup_pkg::q_t    den,
	output kup_pkg::side_t side
);
	import kup_pkg::*;

	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	mat_t  hpa_s1, hpb_s1, pta_s1, ptb_s1;
	q_t    hxa0_s1, hxb0_s1, hxa1_s1, hxb1_s1;
	in_t   it_s1;
	mat_t  hp_s2, pht_s2, pht_s3, pht_s4, pht_s5;
	side_t side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	mat_t  sa_s3, sb_s3;
	mat_t  s_s4;
	q_t    deta_s5, detb_s5;
	mat_t  adj_s5;
	q_t    det_s6, det_s7;
	mat_t  ma_s6, mb_s6;
	mat_t  num_s7;
	mat_t  h, r;

	assign h = cfg.h;
	assign r = cfg.r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// H*P, P*H^T and H*x products
			hpa_s1.m00 <= mulq(h.m00, item.p.m00);
			hpb_s1.m00 <= mulq(h.m01, item.p.m10);
			hpa_s1.m01 <= mulq(h.m00, item.p.m01);
			hpb_s1.m01 <= mulq(h.m01, item.p.m11);
			hpa_s1.m10 <= mulq(h.m10, item.p.m00);
			hpb_s1.m10 <= mulq(h.m11, item.p.m10);
			hpa_s1.m11 <= mulq(h.m10, item.p.m01);
			hpb_s1.m11 <= mulq(h.m11, item.p.m11);
			pta_s1.m00 <= mulq(item.p.m00, h.m00);
			ptb_s1.m00 <= mulq(item.p.m01, h.m01);
			pta_s1.m01 <= mulq(item.p.m00, h.m10);
			ptb_s1.m01 <= mulq(item.p.m01, h.m11);
			pta_s1.m10 <= mulq(item.p.m10, h.m00);
			ptb_s1.m10 <= mulq(item.p.m11, h.m01);
			pta_s1.m11 <= mulq(item.p.m10, h.m10);
			ptb_s1.m11 <= mulq(item.p.m11, h.m11);
			hxa0_s1    <= mulq(h.m00, item.x0);
			hxb0_s1    <= mulq(h.m01, item.x1);
			hxa1_s1    <= mulq(h.m10, item.x0);
			hxb1_s1    <= mulq(h.m11, item.x1);
			it_s1      <= item;

			hp_s2.m00    <= sadd(hpa_s1.m00, hpb_s1.m00);
			hp_s2.m01    <= sadd(hpa_s1.m01, hpb_s1.m01);
			hp_s2.m10    <= sadd(hpa_s1.m10, hpb_s1.m10);
			hp_s2.m11    <= sadd(hpa_s1.m11, hpb_s1.m11);
			pht_s2.m00   <= sadd(pta_s1.m00, ptb_s1.m00);
			pht_s2.m01   <= sadd(pta_s1.m01, ptb_s1.m01);
			pht_s2.m10   <= sadd(pta_s1.m10, ptb_s1.m10);
			pht_s2.m11   <= sadd(pta_s1.m11, ptb_s1.m11);
			side_s2.x0   <= it_s1.x0;
			side_s2.x1   <= it_s1.x1;
			side_s2.p    <= it_s1.p;
			side_s2.y0   <= ssub(it_s1.z0, sadd(hxa0_s1, hxb0_s1));
			side_s2.y1   <= ssub(it_s1.z1, sadd(hxa1_s1, hxb1_s1));
			side_s2.sing <= 1'b0;

			// (H*P)*H^T products
			sa_s3.m00 <= mulq(hp_s2.m00, h.m00);
			sb_s3.m00 <= mulq(hp_s2.m01, h.m01);
			sa_s3.m01 <= mulq(hp_s2.m00, h.m10);
			sb_s3.m01 <= mulq(hp_s2.m01, h.m11);
			sa_s3.m10 <= mulq(hp_s2.m10, h.m00);
			sb_s3.m10 <= mulq(hp_s2.m11, h.m01);
			sa_s3.m11 <= mulq(hp_s2.m10, h.m10);
			sb_s3.m11 <= mulq(hp_s2.m11, h.m11);
			pht_s3    <= pht_s2;
			side_s3   <= side_s2;

			s_s4.m00 <= sadd(sadd(sa_s3.m00, sb_s3.m00), r.m00);
			s_s4.m01 <= sadd(sadd(sa_s3.m01, sb_s3.m01), r.m01);
			s_s4.m10 <= sadd(sadd(sa_s3.m10, sb_s3.m10), r.m10);
			s_s4.m11 <= sadd(sadd(sa_s3.m11, sb_s3.m11), r.m11);
			pht_s4   <= pht_s3;
			side_s4  <= side_s3;

			deta_s5    <= mulq(s_s4.m00, s_s4.m11);
			detb_s5    <= mulq(s_s4.m01, s_s4.m10);
			adj_s5.m00 <= s_s4.m11;
			adj_s5.m01 <= ssub(ZERO, s_s4.m01);
			adj_s5.m10 <= ssub(ZERO, s_s4.m10);
			adj_s5.m11 <= s_s4.m00;
			pht_s5     <= pht_s4;
			side_s5    <= side_s4;

			// P*H^T*adj(S) products
			det_s6    <= ssub(deta_s5, detb_s5);
			ma_s6.m00 <= mulq(pht_s5.m00, adj_s5.m00);
			mb_s6.m00 <= mulq(pht_s5.m01, adj_s5.m10);
			ma_s6.m01 <= mulq(pht_s5.m00, adj_s5.m01);
			mb_s6.m01 <= mulq(pht_s5.m01, adj_s5.m11);
			ma_s6.m10 <= mulq(pht_s5.m10, adj_s5.m00);
			mb_s6.m10 <= mulq(pht_s5.m11, adj_s5.m10);
			ma_s6.m11 <= mulq(pht_s5.m10, adj_s5.m01);
			mb_s6.m11 <= mulq(pht_s5.m11, adj_s5.m11);
			side_s6   <= side_s5;

			num_s7.m00 <= sadd(ma_s6.m00, mb_s6.m00);
			num_s7.m01 <= sadd(ma_s6.m01, mb_s6.m01);
			num_s7.m10 <= sadd(ma_s6.m10, mb_s6.m10);
			num_s7.m11 <= sadd(ma_s6.m11, mb_s6.m11);
			det_s7     <= det_s6;
			// sing is the last field: replace it with the zero-determinant test
			side_s7    <= {side_s6[$bits(side_t)-1:1], det_s6 == ZERO};
		end
	end

	assign out_vld = v_s7;
	assign num     = num_s7;
	assign den     = det_s7;
	assign side    = side_s7;

endmodule

[rtl/core/kup_div.sv]
module kup_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  kup_pkg::mat_t  num,
	input  kup_pkg::q_t    den,
	input  kup_pkg::side_t side_in,
	output logic           out_vld,
	output kup_pkg::mat_t  gain,
	output kup_pkg::side_t side_out
);
	import kup_pkg::*;

	localparam int QW = DW + FB;
	localparam int NS = DIV_STAGES;

	localparam logic [QW-1:0] QLIM_POS = {{(FB+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [QW-1:0] QLIM_NEG = {{FB{1'b0}}, 1'b1, {(DW-1){1'b0}}};

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QW-1:0] dvd;
		logic [QW-1:0] quo;
		logic          neg;
	} lane_t;

	logic          v_s   [NS+2];
	lane_t         ln_s  [NS+1][4];
	logic [DW-1:0] den_s [NS+1];
	side_t         side_s[NS+2];
	mat_t          k_s;
	q_t            nv    [4];

	// DIV_STEPS restoring steps: shift in one dividend bit, subtract when it fits
	function automatic lane_t div_steps(lane_t l, logic [DW-1:0] d);
		logic [DW:0] t;
		lane_t       o;
		o = l;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t     = {o.rem, o.dvd[QW-1]};
			o.dvd = o.dvd << 1;
			if (t >= {1'b0, d}) begin
				t     = t - {1'b0, d};
				o.quo = {o.quo[QW-2:0], 1'b1};
			end else begin
				o.quo = {o.quo[QW-2:0], 1'b0};
			end
			o.rem = t[DW-1:0];
		end
		return o;
	endfunction

	function automatic q_t q_sat(lane_t l);
		logic [QW-1:0] m;
		m = l.quo;
		if (l.neg) begin
			if (m > QLIM_NEG) begin
				m = QLIM_NEG;
			end
			return q_t'(~m[DW-1:0] + 1'b1);
		end
		if (m > QLIM_POS) begin
			m = QLIM_POS;
		end
		return q_t'(m[DW-1:0]);
	endfunction

	assign nv[0] = num.m00;
	assign nv[1] = num.m01;
	assign nv[2] = num.m10;
	assign nv[3] = num.m11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NS + 2; g++) begin
				v_s[g] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= in_vld;
			for (int g = 1; g < NS + 2; g++) begin
				v_s[g] <= v_s[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				ln_s[0][k].rem <= '0;
				ln_s[0][k].dvd <= {qmag(nv[k]), {FB{1'b0}}};
				ln_s[0][k].quo <= '0;
				ln_s[0][k].neg <= nv[k][DW-1] ^ den[DW-1];
			end
			den_s[0]  <= qmag(den);
			side_s[0] <= side_in;
		end
	end

	for (genvar g = 1; g <= NS; g++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 4; k++) begin
					ln_s[g][k] <= div_steps(ln_s[g-1][k], den_s[g-1]);
				end
				den_s[g]  <= den_s[g-1];
				side_s[g] <= side_s[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s.m00      <= q_sat(ln_s[NS][0]);
			k_s.m01      <= q_sat(ln_s[NS][1]);
			k_s.m10      <= q_sat(ln_s[NS][2]);
			k_s.m11      <= q_sat(ln_s[NS][3]);
			side_s[NS+1] <= side_s[NS];
		end
	end

	assign out_vld  = v_s[NS+1];
	assign gain     = k_s;
	assign side_out = side_s[NS+1];

endmodule

[rtl/core/kup_back.sv]
module kup_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  kup_pkg::mat_t  gain,
	input  kup_pkg::side_t side,
	input  kup_pkg::mat_t  h,
	output logic           out_vld,
	output kup_pkg::res_t  res
);
	import kup_pkg::*;

	logic  v_s1, v_s2, v_s3, v_s4;
	q_t    kya0_s1, kyb0_s1, kya1_s1, kyb1_s1;
	mat_t  kha_s1, khb_s1;
	side_t side_s1, side_s2, side_s3;
	q_t    xo0_s2, xo1_s2, xo0_s3, xo1_s3;
	mat_t  ikh_s2;
	mat_t  pa_s3, pb_s3;
	res_t  res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kya0_s1    <= mulq(gain.m00, side.y0);
			kyb0_s1    <= mulq(gain.m01, side.y1);
			kya1_s1    <= mulq(gain.m10, side.y0);
			kyb1_s1    <= mulq(gain.m11, side.y1);
			kha_s1.m00 <= mulq(gain.m00, h.m00);
			khb_s1.m00 <= mulq(gain.m01, h.m10);
			kha_s1.m01 <= mulq(gain.m00, h.m01);
			khb_s1.m01 <= mulq(gain.m01, h.m11);
			kha_s1.m10 <= mulq(gain.m10, h.m00);
			khb_s1.m10 <= mulq(gain.m11, h.m10);
			kha_s1.m11 <= mulq(gain.m10, h.m01);
			khb_s1.m11 <= mulq(gain.m11, h.m11);
			side_s1    <= side;

			xo0_s2     <= sadd(side_s1.x0, sadd(kya0_s1, kyb0_s1));
			xo1_s2     <= sadd(side_s1.x1, sadd(kya1_s1, kyb1_s1));
			ikh_s2.m00 <= ssub(ONE, sadd(kha_s1.m00, khb_s1.m00));
			ikh_s2.m01 <= ssub(ZERO, sadd(kha_s1.m01, khb_s1.m01));
			ikh_s2.m10 <= ssub(ZERO, sadd(kha_s1.m10, khb_s1.m10));
			ikh_s2.m11 <= ssub(ONE, sadd(kha_s1.m11, khb_s1.m11));
			side_s2    <= side_s1;

			pa_s3.m00 <= mulq(ikh_s2.m00, side_s2.p.m00);
			pb_s3.m00 <= mulq(ikh_s2.m01, side_s2.p.m10);
			pa_s3.m01 <= mulq(ikh_s2.m00, side_s2.p.m01);
			pb_s3.m01 <= mulq(ikh_s2.m01, side_s2.p.m11);
			pa_s3.m10 <= mulq(ikh_s2.m10, side_s2.p.m00);
			pb_s3.m10 <= mulq(ikh_s2.m11, side_s2.p.m10);
			pa_s3.m11 <= mulq(ikh_s2.m10, side_s2.p.m01);
			pb_s3.m11 <= mulq(ikh_s2.m11, side_s2.p.m11);
			xo0_s3    <= xo0_s2;
			xo1_s3    <= xo1_s2;
			side_s3   <= side_s2;

			// singular innovation: pass the prediction through
			res_s4.sing <= side_s3.sing;
			if (side_s3.sing) begin
				res_s4.x0 <= side_s3.x0;
				res_s4.x1 <= side_s3.x1;
				res_s4.p  <= side_s3.p;
			end else begin
				res_s4.x0    <= xo0_s3;
				res_s4.x1    <= xo1_s3;
				res_s4.p.m00 <= sadd(pa_s3.m00, pb_s3.m00);
				res_s4.p.m01 <= sadd(pa_s3.m01, pb_s3.m01);
				res_s4.p.m10 <= sadd(pa_s3.m10, pb_s3.m10);
				res_s4.p.m11 <= sadd(pa_s3.m11, pb_s3.m11);
			end
		end
	end

	assign out_vld = v_s4;
	assign res     = res_s4;

endmodule

[rtl/core/kalman_update_2state.sv]
// Two-state Kalman measurement update, signed Q16.16 throughout.
// Input channel: in_valid / in_stall with predicted state, prior covariance
// and measurement. Output channel: out_valid / out_stall with corrected state,
// corrected covariance and the singular flag (prediction passed through when
// the innovation determinant is zero). Every item gives exactly one result.
// H and R are loaded through cfg_we / cfg_index / cfg_data; the user must load them
// only while no item is in flight, as the block itself does not enforce it;
// indexes above 7 are ignored. Pipeline: 7 front stages, 14 divider stages,
// 4 back stages, 1 output register. Throughput: one item per cycle while in_stall is low;
// the gain divider resolves 4 quotient bits per stage over 12 stages.
// Reset clears all valid bits and the skid slot and loads H = R = identity.
// When the receiver stalls, the pipeline moves one more item into a skid
// register and then in_stall rises until the output register drains; no item
// is dropped or repeated.
module kalman_update_2state (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [kup_pkg::IDX_W-1:0] cfg_index,
	input  kup_pkg::q_t              cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  kup_pkg::q_t              pred_state_0,
	input  kup_pkg::q_t              pred_state_1,
	input  kup_pkg::q_t              prior_cov_00,
	input  kup_pkg::q_t              prior_cov_01,
	input  kup_pkg::q_t              prior_cov_10,
	input  kup_pkg::q_t              prior_cov_11,
	input  kup_pkg::q_t              meas_0,
	input  kup_pkg::q_t              meas_1,
	output logic                     out_valid,
	input  logic                     out_stall,
	output kup_pkg::q_t              post_state_0,
	output kup_pkg::q_t              post_state_1,
	output kup_pkg::q_t              post_cov_00,
	output kup_pkg::q_t              post_cov_01,
	output kup_pkg::q_t              post_cov_10,
	output kup_pkg::q_t              post_cov_11,
	output logic                     singular
);
	import kup_pkg::*;

	cfg_t  cfg_q;
	in_t   item;
	logic  en;
	logic  f_vld, d_vld, b_vld;
	mat_t  f_num, d_gain;
	q_t    f_den;
	side_t f_side, d_side;
	res_t  b_res;
	logic  out_vld_q, skid_vld_q;
	res_t  out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.h <= '{m00: ONE, m01: ZERO, m10: ZERO, m11: ONE};
			cfg_q.r <= '{m00: ONE, m01: ZERO, m10: ZERO, m11: ONE};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MEAS_MAP_00:  cfg_q.h.m00 <= cfg_data;
				REG_MEAS_MAP_01:  cfg_q.h.m01 <= cfg_data;
				REG_MEAS_MAP_10:  cfg_q.h.m10 <= cfg_data;
				REG_MEAS_MAP_11:  cfg_q.h.m11 <= cfg_data;
				REG_NOISE_COV_00: cfg_q.r.m00 <= cfg_data;
				REG_NOISE_COV_01: cfg_q.r.m01 <= cfg_data;
				REG_NOISE_COV_10: cfg_q.r.m10 <= cfg_data;
				REG_NOISE_COV_11: cfg_q.r.m11 <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item.x0    = pred_state_0;
	assign item.x1    = pred_state_1;
	assign item.p.m00 = prior_cov_00;
	assign item.p.m01 = prior_cov_01;
	assign item.p.m10 = prior_cov_10;
	assign item.p.m11 = prior_cov_11;
	assign item.z0    = meas_0;
	assign item.z1    = meas_1;

	// the whole pipeline advances unless the skid slot is occupied
	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	kup_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.item   (item),
		.cfg    (cfg_q),
		.out_vld(f_vld),
		.num    (f_num),
		.den    (f_den),
		.side   (f_side)
	);

	kup_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (f_vld),
		.num     (f_num),
		.den     (f_den),
		.side_in (f_side),
		.out_vld (d_vld),
		.gain    (d_gain),
		.side_out(d_side)
	);

	kup_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (d_vld),
		.gain   (d_gain),
		.side   (d_side),
		.h      (cfg_q.h),
		.out_vld(b_vld),
		.res    (b_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !out_stall) begin
			out_vld_q  <= skid_vld_q || b_vld;
			skid_vld_q <= 1'b0;
		end else if (b_vld && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !out_stall) begin
			out_q <= skid_vld_q ? skid_q : b_res;
		end else if (b_vld && en) begin
			skid_q <= b_res;
		end
	end

	assign out_valid    = out_vld_q;
	assign post_state_0 = out_q.x0;
	assign post_state_1 = out_q.x1;
	assign post_cov_00  = out_q.p.m00;
	assign post_cov_01  = out_q.p.m01;
	assign post_cov_10  = out_q.p.m10;
	assign post_cov_11  = out_q.p.m11;
	assign singular     = out_q.sing;

endmodule
